[hw/rtl/sfb_pkg.sv]
// ----------------------------------------------------------------------------
// sfb_pkg
// Types and constants for the sensor frame builder with CRC-8 trailer.
// ----------------------------------------------------------------------------
package sfb_pkg;

    // One measurement beat on the input channel.
    typedef struct packed {
        logic [15:0] temperature;
        logic [15:0] humidity;
        logic [7:0]  battery_level;
    } t_in_beat;

    // One frame byte on the output channel.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_out_beat;

    typedef logic [3:0] t_byte_pos;

    // Byte positions within the ten-byte frame.
    localparam t_byte_pos POS_START  = 4'd0;
    localparam t_byte_pos POS_ID     = 4'd1;
    localparam t_byte_pos POS_LEN    = 4'd2;
    localparam t_byte_pos POS_TYPE   = 4'd3;
    localparam t_byte_pos POS_TEMP_H = 4'd4;
    localparam t_byte_pos POS_TEMP_L = 4'd5;
    localparam t_byte_pos POS_HUM_H  = 4'd6;
    localparam t_byte_pos POS_HUM_L  = 4'd7;
    localparam t_byte_pos POS_BATT   = 4'd8;
    localparam t_byte_pos POS_CRC    = 4'd9;

    localparam logic [7:0] START_BYTE      = 8'hCC;
    localparam logic [7:0] DATA_LEN        = 8'd6;
    localparam logic [7:0] SENSOR_TYPE     = 8'hF7;
    localparam logic [7:0] CRC_POLY        = 8'h31;
    localparam logic [7:0] SENSOR_ID_RESET = 8'd3;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/sensor_frame_builder_crc8_core.sv]
// ----------------------------------------------------------------------------
// sensor_frame_builder_crc8_core
// Turns one measurement beat into a ten-byte radio frame with CRC-8 trailer.
// ----------------------------------------------------------------------------
// Each accepted measurement yields ten output beats, one frame byte each:
// 0xCC, sensor id, length 6, type 0xF7, temperature MSB/LSB, humidity
// MSB/LSB, battery level and a CRC-8 (poly 0x31, init 0) over the first nine
// bytes; the CRC beat carries last_byte. The output serializer sends one byte
// per cycle while the output is not stalled. A one-entry input register
// takes the next measurement while the current frame is still being sent, so
// frames follow each other without gaps. The CRC is accumulated byte by byte
// as beats leave. The sensor id register resets to 3 and the configuration
// port is always ready.
module sensor_frame_builder_crc8_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sfb_pkg::t_in_beat i_in_beat,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output sfb_pkg::t_out_beat o_out_beat,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);
    import sfb_pkg::*;

    logic [7:0] r_id;
    logic [7:0] n_id;

    logic      r_hold_valid, n_hold_valid;
    t_in_beat  r_hold, n_hold;
    logic      r_busy, n_busy;
    t_in_beat  r_frame, n_frame;
    t_byte_pos r_pos, n_pos;
    logic [7:0] r_crc, n_crc;

    logic       in_fire;
    logic       out_fire;
    logic       frame_done;
    logic       load;
    logic [7:0] cur_byte;

    assign o_cfg_ready = 1'b1;

    assign in_fire    = i_in_valid && !r_hold_valid;
    assign out_fire   = r_busy && !i_out_stall;
    assign frame_done = out_fire && (r_pos == POS_CRC);
    assign load       = r_hold_valid && (!r_busy || frame_done);

    assign o_in_stall  = r_hold_valid;
    assign o_out_valid = r_busy;

    always_comb begin
        unique case (r_pos)
            POS_START:  cur_byte = START_BYTE;
            POS_ID:     cur_byte = r_id;
            POS_LEN:    cur_byte = DATA_LEN;
            POS_TYPE:   cur_byte = SENSOR_TYPE;
            POS_TEMP_H: cur_byte = r_frame.temperature[15:8];
            POS_TEMP_L: cur_byte = r_frame.temperature[7:0];
            POS_HUM_H:  cur_byte = r_frame.humidity[15:8];
            POS_HUM_L:  cur_byte = r_frame.humidity[7:0];
            POS_BATT:   cur_byte = r_frame.battery_level;
            default:    cur_byte = r_crc;
        endcase
    end

    assign o_out_beat.frame_byte = cur_byte;
    assign o_out_beat.last_byte  = (r_pos == POS_CRC);

    always_comb begin
        n_id = i_cfg_valid ? i_cfg_data : r_id;

        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if (in_fire) begin
            n_hold_valid = 1'b1;
            n_hold       = i_in_beat;
        end else if (load) begin
            n_hold_valid = 1'b0;
        end

        n_busy  = r_busy;
        n_frame = r_frame;
        n_pos   = r_pos;
        n_crc   = r_crc;
        if (load) begin
            n_busy  = 1'b1;
            n_frame = r_hold;
            n_pos   = POS_START;
            n_crc   = 8'd0;
        end else if (frame_done) begin
            n_busy = 1'b0;
        end else if (out_fire) begin
            n_pos = r_pos + 4'd1;
            n_crc = crc8_update(r_crc, cur_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id         <= SENSOR_ID_RESET;
            r_hold_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_pos        <= POS_START;
        end else begin
            r_id         <= n_id;
            r_hold_valid <= n_hold_valid;
            r_busy       <= n_busy;
            r_pos        <= n_pos;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_hold  <= n_hold;
        r_frame <= n_frame;
        r_crc   <= n_crc;
    end

endmodule
